// ===== hw/rtl/gbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the gap buffer line editor.
// ----------------------------------------------------------------------------
package gbe_pkg;

  localparam int unsigned TEXT_DEPTH_DEF = 1024;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_LEFT   = 3'd1,
    MODE_RIGHT  = 3'd2,
    MODE_BACK   = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EDGE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_WAIT = 2'd2
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_in;
    logic [POS_W-1:0]  position;
  } gbe_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  left_length;
    logic [LEN_W-1:0]  right_length;
  } gbe_out_t;

  // completed command handed to the output stage
  typedef struct packed {
    logic     valid;
    gbe_out_t data;
  } gbe_res_t;

endpackage

// ===== hw/rtl/gbe_store.sv =====
// ----------------------------------------------------------------------------
// gbe_store
// Text byte store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gbe_store
  import gbe_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int unsigned AW        = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CHAR_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CHAR_W-1:0] rdata_o
);

  logic [CHAR_W-1:0] mem_q [TEXT_DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbe_ctrl
// Command sequencer: holds the cursor counts, addresses the store and
// builds one result per command.
// ----------------------------------------------------------------------------
module gbe_ctrl
  import gbe_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int unsigned AW        = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1,
  localparam int unsigned CW        = $clog2(TEXT_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  gbe_in_t           cmd_i,
  input  logic              slot_free_i,
  output gbe_res_t          res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [CHAR_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [CHAR_W-1:0] mem_rdata_i
);

  localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TEXT_DEPTH);

  state_e        state_q, state_d;
  gbe_in_t       cmd_q;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] right_q, right_d;

  logic [CW-1:0] used;
  logic          full;
  logic          in_range;
  logic          needs_mem;
  logic [XW-1:0] far_idx;
  logic          finish;

  assign used     = left_q + right_q;
  assign full     = (used == DEPTH_C);
  assign in_range = (XW'(cmd_q.position) < XW'(used));
  assign far_idx  = XW'(cmd_q.position) + XW'(TEXT_DEPTH) - XW'(used);

  always_comb begin
    case (cmd_q.mode)
      MODE_LEFT:  needs_mem = (left_q != '0);
      MODE_RIGHT: needs_mem = (right_q != '0);
      MODE_READ:  needs_mem = in_range;
      default:    needs_mem = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (needs_mem) begin
          state_d = S_WAIT;
        end else if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      S_WAIT: begin
        if (slot_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = (state_q == S_IDLE);
    finish      = slot_free_i &&
                  (((state_q == S_EXEC) && !needs_mem) || (state_q == S_WAIT));

    mem_re_o    = (state_q == S_EXEC) && needs_mem;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(left_q);
    mem_wdata_o = mem_rdata_i;

    left_d            = left_q;
    right_d           = right_q;
    res_o.data.status = ST_DONE;

    case (cmd_q.mode)
      MODE_INSERT: begin
        mem_wdata_o = cmd_q.char_in;
        if (full) begin
          res_o.data.status = ST_FULL;
        end else begin
          mem_we_o = finish;
          left_d   = left_q + CW'(1);
        end
      end
      MODE_LEFT: begin
        mem_raddr_o = AW'(left_q - CW'(1));
        mem_waddr_o = AW'(DEPTH_C - right_q - CW'(1));
        if (left_q == '0) begin
          res_o.data.status = ST_EDGE;
        end else begin
          mem_we_o = finish;
          left_d   = left_q - CW'(1);
          right_d  = right_q + CW'(1);
        end
      end
      MODE_RIGHT: begin
        mem_raddr_o = AW'(DEPTH_C - right_q);
        mem_waddr_o = AW'(left_q);
        if (right_q == '0) begin
          res_o.data.status = ST_EDGE;
        end else begin
          mem_we_o = finish;
          left_d   = left_q + CW'(1);
          right_d  = right_q - CW'(1);
        end
      end
      MODE_BACK: begin
        if (left_q == '0) begin
          res_o.data.status = ST_EDGE;
        end else begin
          left_d = left_q - CW'(1);
        end
      end
      MODE_READ: begin
        if (XW'(cmd_q.position) < XW'(left_q)) begin
          mem_raddr_o = AW'(cmd_q.position);
        end else begin
          mem_raddr_o = AW'(far_idx);
        end
        if (!in_range) begin
          res_o.data.status = ST_RANGE;
        end
      end
      default: res_o.data.status = ST_EDGE;
    endcase

    if (!finish) begin
      left_d  = left_q;
      right_d = right_q;
    end

    res_o.valid             = finish;
    res_o.data.char_out     = ((state_q == S_WAIT) && (cmd_q.mode == MODE_READ)) ?
                              mem_rdata_i : '0;
    res_o.data.left_length  = LEN_W'(left_d);
    res_o.data.right_length = LEN_W'(right_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) begin
      cmd_q <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_counts_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (XW'(left_q) + XW'(right_q)) <= XW'(TEXT_DEPTH))
    else $error("gbe_ctrl: cursor counts exceed store depth");

  a_res_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> slot_free_i)
    else $error("gbe_ctrl: result raised while output slot busy");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !mem_we_o)
    else $error("gbe_ctrl: store written with no command in progress");

  a_left_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (cmd_q.mode == MODE_LEFT) && (res_o.data.status == ST_DONE))
    |=> (left_q == $past(left_q) - CW'(1)) && (right_q == $past(right_q) + CW'(1)))
    else $error("gbe_ctrl: cursor left did not shift the counts");
`endif

endmodule

// ===== hw/rtl/gap_buffer_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// gap_buffer_line_editor_core
// Line editor on a gap buffer: left and right text parts share one byte
// store filled from both ends, edited one command at a time.
// ----------------------------------------------------------------------------
//  channel | signals                                   | payload
//  --------+-------------------------------------------+-----------------------
//  command | in_valid_i / in_ready_o / in_data_i       | mode, char_in, position
//  result  | out_valid_o / out_ready_i / out_data_o    | char_out, status,
//          |                                           | left_length, right_length
//
//  Insert, backspace and edge, full or range cases finish in the execute state;
//  cursor moves and reads pass through a wait state for the store's registered
//  read port. One command is in flight at a time.
//  Reset clears the cursor counts, sequencer state and output valid; the store is not cleared.
//  A result waiting in the output register does not block the next command
//  transfer; the sequencer holds only when its own result finds the slot full.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor_core
  import gbe_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  gbe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output gbe_out_t out_data_o
);

  localparam int unsigned AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

  logic              out_valid_q, out_valid_d;
  gbe_out_t          out_data_q;
  logic              slot_free;
  gbe_res_t          res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CHAR_W-1:0] mem_rdata;

  assign slot_free = !out_valid_q || out_ready_i;

  gbe_ctrl #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_ready_o (in_ready_o),
    .cmd_i       (in_data_i),
    .slot_free_i (slot_free),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  gbe_store #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // hold the result until transfer, load a new one when the slot frees
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
